// ===== design/pip_pkg.sv =====
// Package with shared constants and types of the point-in-polygon test.
`default_nettype none
package pip_pkg;
    localparam int DEF_MAX_VERTICES = 64;
    localparam int DEF_COORD_BITS   = 16;
    localparam int EC_W             = 7;
    localparam int IDX_W            = 6;
    localparam int QW               = 32;
    localparam int FRAC             = 16;
    localparam int EC_RESET         = 3;
    localparam int MIN_EDGES        = 3;

    // Status handed from the edge unit back to the control.
    typedef struct packed {
        logic       busy;
        logic       par;
        logic [1:0] vlo;
    } t_edge_stat;
endpackage
`default_nettype wire

// ===== design/pip_if.sv =====
// Valid/ready channel interfaces for query/vertex beats and result beats.
`default_nettype none
interface pip_in_if #(parameter int CB = pip_pkg::DEF_COORD_BITS);
    logic                          valid;
    logic                          ready;
    logic                          op;
    logic [pip_pkg::IDX_W-1:0]     vertex_index;
    logic signed [CB-1:0]          vertex_x;
    logic signed [CB-1:0]          vertex_y;
    logic signed [pip_pkg::QW-1:0] query_x;
    logic signed [pip_pkg::QW-1:0] query_y;
    modport source (output valid, op, vertex_index, vertex_x, vertex_y, query_x, query_y,
                    input ready);
    modport sink (input valid, op, vertex_index, vertex_x, vertex_y, query_x, query_y,
                  output ready);
endinterface

interface pip_out_if;
    logic valid;
    logic ready;
    logic inside_res;
    logic answered;
    modport source (output valid, inside_res, answered, input ready);
    modport sink (input valid, inside_res, answered, output ready);
endinterface
`default_nettype wire

// ===== design/pip_cell.sv =====
// One cell of the vertex window: holds a vertex and passes it on when shifted.
`default_nettype none
module pip_cell #(
    parameter int DW = 2 * pip_pkg::DEF_COORD_BITS
) (
    input  wire logic          i_clk,
    input  wire logic          i_shift,
    input  wire logic [DW-1:0] i_d,
    output logic [DW-1:0]      o_q
);
    logic [DW-1:0] r_q;

    // Take the neighbor's vertex on every shift.
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_q <= i_d;
        end
    end

    assign o_q = r_q;
endmodule
`default_nettype wire

// ===== design/pip_edge.sv =====
// Edge evaluation: classifies one edge, forms the cross products, counts crossings.
`default_nettype none
module pip_edge #(
    parameter int CB = pip_pkg::DEF_COORD_BITS
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_clear,
    input  wire logic                 i_valid,
    input  wire logic [2*CB-1:0]      i_vp,
    input  wire logic [2*CB-1:0]      i_va,
    input  wire logic [2*CB-1:0]      i_vb,
    input  wire logic [2*CB-1:0]      i_vc,
    input  wire logic [pip_pkg::QW-1:0] i_qx,
    input  wire logic [pip_pkg::QW-1:0] i_qy,
    output pip_pkg::t_edge_stat       o_stat
);
    import pip_pkg::*;

    localparam int W  = ((CB + FRAC > QW) ? CB + FRAC : QW) + 1;
    localparam int PW = W + CB + 1;
    localparam logic [1:0] M_NONE  = 2'd0;
    localparam logic [1:0] M_CNT   = 2'd1;
    localparam logic [1:0] M_VTX   = 2'd2;
    localparam logic [1:0] M_CROSS = 2'd3;

    logic signed [CB-1:0] xp, yp, xa, ya, xb, yb, xc, yc;
    logic signed [W-1:0]  qxw, qyw, Xa, Xb, Yp, Ya, Yb, Yc, xmax, ymin, ymax, da, ea;
    logic signed [CB:0]   dy, dx;
    logic signed [PW-1:0] p1, p2;
    logic sp_pos, sp_neg, sa_pos, sa_neg, sb_pos, sb_neg, sc_pos, sc_neg;
    logic horiz, eqa, eqb;
    logic [1:0] mode;

    logic                 r_v, r_dyneg;
    logic [1:0]           r_mode;
    logic signed [PW-1:0] r_p1, r_p2;
    logic signed [PW:0]   sum;
    logic                 hit;
    logic                 r_par;
    logic [1:0]           r_vlo;

    // Unpack the window and scale coordinates to Q16.16 at a common width.
    assign {xp, yp} = i_vp;
    assign {xa, ya} = i_va;
    assign {xb, yb} = i_vb;
    assign {xc, yc} = i_vc;
    assign qxw = {{(W-QW){i_qx[QW-1]}}, i_qx};
    assign qyw = {{(W-QW){i_qy[QW-1]}}, i_qy};
    assign Xa  = {{(W-CB-FRAC){xa[CB-1]}}, xa, {FRAC{1'b0}}};
    assign Xb  = {{(W-CB-FRAC){xb[CB-1]}}, xb, {FRAC{1'b0}}};
    assign Yp  = {{(W-CB-FRAC){yp[CB-1]}}, yp, {FRAC{1'b0}}};
    assign Ya  = {{(W-CB-FRAC){ya[CB-1]}}, ya, {FRAC{1'b0}}};
    assign Yb  = {{(W-CB-FRAC){yb[CB-1]}}, yb, {FRAC{1'b0}}};
    assign Yc  = {{(W-CB-FRAC){yc[CB-1]}}, yc, {FRAC{1'b0}}};

    // Sides of the four window vertices relative to the ray.
    assign sp_pos = Yp > qyw;
    assign sp_neg = Yp < qyw;
    assign sa_pos = Ya > qyw;
    assign sa_neg = Ya < qyw;
    assign sb_pos = Yb > qyw;
    assign sb_neg = Yb < qyw;
    assign sc_pos = Yc > qyw;
    assign sc_neg = Yc < qyw;

    assign horiz = (ya == yb) && (xa != xb);
    assign eqa   = Ya == qyw;
    assign eqb   = Yb == qyw;
    assign xmax  = (Xa > Xb) ? Xa : Xb;
    assign ymin  = (Ya < Yb) ? Ya : Yb;
    assign ymax  = (Ya < Yb) ? Yb : Ya;

    // Classify the edge.
    always_comb begin
        mode = M_NONE;
        if (horiz) begin
            if (eqa && (xmax >= qxw) && !((sp_pos && sc_pos) || (sp_neg && sc_neg))) begin
                mode = M_CNT;
            end
        end else if ((qyw >= ymin) && (qyw <= ymax)) begin
            if (eqa) begin
                if ((Xa >= qxw) && ((sp_pos && sb_neg) || (sp_neg && sb_pos))) begin
                    mode = M_VTX;
                end
            end else if (eqb) begin
                if ((Xb >= qxw) && ((sa_pos && sc_neg) || (sa_neg && sc_pos))) begin
                    mode = M_VTX;
                end
            end else begin
                mode = M_CROSS;
            end
        end
    end

    // Cross product terms of the crossing test.
    assign dy = {yb[CB-1], yb} - {ya[CB-1], ya};
    assign dx = {xb[CB-1], xb} - {xa[CB-1], xa};
    assign da = Xa - qxw;
    assign ea = qyw - Ya;
    assign p1 = da * dy;
    assign p2 = ea * dx;

    // Register the classification and products.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode   <= mode;
        r_dyneg  <= dy[CB];
        r_p1     <= p1;
        r_p2     <= p2;
    end

    // Sign of the sum decides a proper crossing.
    assign sum = {r_p1[PW-1], r_p1} + {r_p2[PW-1], r_p2};
    assign hit = r_dyneg ? (sum <= 0) : (sum >= 0);

    // Count parity and low bits of the vertex crossings.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_par <= 1'b0;
            r_vlo <= 2'd0;
        end else if (r_v) begin
            case (r_mode)
                M_CNT:   r_par <= ~r_par;
                M_VTX: begin
                    r_par <= ~r_par;
                    r_vlo <= r_vlo + 2'd1;
                end
                M_CROSS: r_par <= r_par ^ hit;
                default: r_par <= r_par;
            endcase
        end
    end

    assign o_stat.busy = r_v;
    assign o_stat.par  = r_par;
    assign o_stat.vlo  = r_vlo;
endmodule
`default_nettype wire

// ===== design/point_in_polygon_test.sv =====
// Top level of the point-in-polygon test: vertex table, window cells and control.
// A vertex write beat is acknowledged in the cycle after it is taken. A query beat walks
// the edge_count edges (clamped to 3..MAX_VERTICES) one edge a cycle: the table is read
// once per cycle for n+3 reads that stream through a four-cell vertex window, and the
// answer follows once the last edge has drained. One query or write is in work at a time;
// the single table read port sets the rate.
`default_nettype none
module point_in_polygon_test #(
    parameter int MAX_VERTICES = pip_pkg::DEF_MAX_VERTICES,
    parameter int COORD_BITS   = pip_pkg::DEF_COORD_BITS
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [pip_pkg::EC_W-1:0] i_cfg_data,
    pip_in_if.sink                    i_in,
    pip_out_if.source                 o_out
);
    import pip_pkg::*;

    localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int DW = 2 * COORD_BITS;
    localparam int NW = AW + 1;
    localparam int CW = AW + 2;
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_RUN   = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;

    logic [EC_W-1:0]   r_edge_count;
    logic [1:0]        r_state;
    logic [AW-1:0]     r_addr;
    logic [CW-1:0]     r_rcnt;
    logic [QW-1:0]     r_qx, r_qy;
    logic [DW-1:0]     mem [MAX_VERTICES];
    logic [DW-1:0]     r_rdata;
    logic              r_dv, r_df, r_wv;
    logic              r_ov, r_oin, r_oans;
    logic [NW-1:0]     n;
    logic [NW-1:0]     nm1;
    logic              accept, wr_ok, last_rd, finish;
    logic [DW-1:0]     cell_q [4];
    t_edge_stat        stat;

    // Clamp the edge count to the usable range.
    always_comb begin
        if (int'(r_edge_count) < MIN_EDGES) begin
            n = NW'(MIN_EDGES);
        end else if (int'(r_edge_count) > MAX_VERTICES) begin
            n = NW'(MAX_VERTICES);
        end else begin
            n = NW'(r_edge_count);
        end
    end
    assign nm1 = n - NW'(1);

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edge_count <= EC_W'(EC_RESET);
        end else if (i_cfg_we) begin
            r_edge_count <= i_cfg_data;
        end
    end

    assign i_in.ready = (r_state == S_IDLE) && (!r_ov || o_out.ready);
    assign accept     = i_in.valid && i_in.ready;
    assign wr_ok      = int'(i_in.vertex_index) < MAX_VERTICES;
    assign last_rd    = r_rcnt == CW'(n + NW'(2));
    assign finish     = (r_state == S_DRAIN) && !r_dv && !r_wv && !stat.busy;

    // Control sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (accept && i_in.op) begin
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    if (last_rd) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (finish) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Read address walk, starting at the last vertex and wrapping.
    always_ff @(posedge i_clk) begin
        if (accept && i_in.op) begin
            r_addr <= AW'(nm1);
            r_rcnt <= '0;
            r_qx   <= i_in.query_x;
            r_qy   <= i_in.query_y;
        end else if (r_state == S_RUN) begin
            r_addr <= (NW'(r_addr) == nm1) ? '0 : r_addr + AW'(1);
            r_rcnt <= r_rcnt + CW'(1);
        end
    end

    // Vertex table.
    always_ff @(posedge i_clk) begin
        if (accept && !i_in.op && wr_ok) begin
            mem[AW'(i_in.vertex_index)] <= {i_in.vertex_x, i_in.vertex_y};
        end
        r_rdata <= mem[r_addr];
    end

    // Read data valid and window valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv <= 1'b0;
            r_df <= 1'b0;
            r_wv <= 1'b0;
        end else begin
            r_dv <= r_state == S_RUN;
            r_df <= r_rcnt >= CW'(3);
            r_wv <= r_dv && r_df;
        end
    end

    // Four-cell vertex window: next, end, start, previous.
    for (genvar k = 0; k < 4; k++) begin : g_cell
        pip_cell #(.DW(DW)) u_cell (
            .i_clk   (i_clk),
            .i_shift (r_dv),
            .i_d     ((k == 0) ? r_rdata : cell_q[(k == 0) ? 0 : k-1]),
            .o_q     (cell_q[k])
        );
    end

    pip_edge #(.CB(COORD_BITS)) u_edge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (accept && i_in.op),
        .i_valid (r_wv),
        .i_vp    (cell_q[3]),
        .i_va    (cell_q[2]),
        .i_vb    (cell_q[1]),
        .i_vc    (cell_q[0]),
        .i_qx    (r_qx),
        .i_qy    (r_qy),
        .o_stat  (stat)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (accept && !i_in.op) begin
            r_ov <= 1'b1;
        end else if (finish) begin
            r_ov <= 1'b1;
        end else if (o_out.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && !i_in.op) begin
            r_oin  <= 1'b0;
            r_oans <= 1'b0;
        end else if (finish) begin
            r_oin  <= stat.par ^ stat.vlo[1];
            r_oans <= 1'b1;
        end
    end

    assign o_out.valid      = r_ov;
    assign o_out.inside_res = r_oin;
    assign o_out.answered   = r_oans;

    // The walk never addresses past the clamped vertex count.
    a_addr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> (NW'(r_addr) < n))
        else $error("table address beyond vertex count");

    // Nothing is taken while a query is in work.
    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !i_in.ready)
        else $error("input taken while busy");

    // A write acknowledgment never reports inside.
    a_ack_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !r_oans) |-> !r_oin)
        else $error("write acknowledge with inside set");

    // A finished query returns to idle with an answered result beat pending.
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        finish |=> (r_state == S_IDLE) && r_ov && r_oans)
        else $error("query answer missing");
endmodule
`default_nettype wire

// ===== bench/pip_tb_pkg.sv =====
// Bench-side item and result types for the point-in-polygon bench.
package pip_tb_pkg;
    typedef struct {
        logic               op;
        logic [5:0]         vertex_index;
        logic signed [15:0] vertex_x;
        logic signed [15:0] vertex_y;
        logic signed [31:0] query_x;
        logic signed [31:0] query_y;
    } t_pip_item;

    typedef struct {
        logic inside_res;
        logic answered;
    } t_pip_answer;

    localparam logic OP_VERTEX = 1'b0;
    localparam logic OP_QUERY  = 1'b1;
endpackage

// ===== bench/tb_top.sv =====
// Bench for the point-in-polygon test: random polygons, queries and a crossing predictor.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import pip_pkg::*;
    import pip_tb_pkg::*;

    localparam int  NVERT       = 64;
    localparam longint CYCLE_LIMIT = 2_000_000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [EC_W-1:0] i_cfg_data = '0;

    pip_in_if  in_ch ();
    pip_out_if out_ch ();

    point_in_polygon_test dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_in(in_ch.sink), .o_out(out_ch.source)
    );

    // Clock with a 12 ns period.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Predictor state: the vertex table and the edge count.
    longint poly_x [NVERT];
    longint poly_y [NVERT];
    int     edge_setting;

    t_pip_item   pending_items[$];
    t_pip_answer answers_due[$];
    int  mismatch_count = 0;
    longint cycle_count = 0;
    bit  idle_enable = 1'b1;
    bit  hold_sender = 1'b0;
    bit  in_taken = 1'b0;

    // Exact sign of a*b + c*d; operands fit comfortably in 128 bits.
    function automatic int sign_of_sum(longint a, longint b, longint c, longint d);
        logic signed [127:0] s;
        s = 128'(signed'(a)) * 128'(signed'(b)) + 128'(signed'(c)) * 128'(signed'(d));
        return (s > 0) ? 1 : ((s < 0) ? -1 : 0);
    endfunction

    function automatic int ray_side(int k, longint qy);
        longint v;
        v = poly_y[k] * 65536 - qy;
        return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
    endfunction

    // Crossing-number answer for one query point.
    function automatic logic crossing_parity(longint qx, longint qy);
        int n, j, pv, nx, v, a, b, s1, s2, s;
        longint cnt, vcnt, y1, y2, x1, x2, ymin, ymax, xmax;
        n = (edge_setting < 3) ? 3 : ((edge_setting > NVERT) ? NVERT : edge_setting);
        cnt = 0;
        vcnt = 0;
        for (int i = 0; i < n; i++) begin
            j = (i + 1) % n;
            pv = (i + n - 1) % n;
            nx = (i + 2) % n;
            x1 = poly_x[i] * 65536; y1 = poly_y[i] * 65536;
            x2 = poly_x[j] * 65536; y2 = poly_y[j] * 65536;
            if (y1 == y2 && x1 != x2) begin
                xmax = (x1 > x2) ? x1 : x2;
                if (y1 == qy && xmax >= qx) begin
                    s1 = ray_side(pv, qy);
                    s2 = ray_side(nx, qy);
                    if (!((s1 > 0 && s2 > 0) || (s1 < 0 && s2 < 0))) cnt++;
                end
                continue;
            end
            ymin = (y1 < y2) ? y1 : y2;
            ymax = (y1 < y2) ? y2 : y1;
            if (qy < ymin || qy > ymax) continue;
            if (qy == y1 || qy == y2) begin
                if (qy == y1) begin
                    v = i; a = pv; b = j;
                end else begin
                    v = j; a = i; b = nx;
                end
                if (poly_x[v] * 65536 < qx) continue;
                s1 = ray_side(a, qy);
                s2 = ray_side(b, qy);
                if ((s1 > 0 && s2 < 0) || (s1 < 0 && s2 > 0)) begin
                    cnt++;
                    vcnt++;
                end
            end else begin
                s = sign_of_sum(x1 - qx, poly_y[j] - poly_y[i], qy - y1,
                                poly_x[j] - poly_x[i]);
                if (poly_y[j] - poly_y[i] < 0) s = -s;
                if (s >= 0) cnt++;
            end
        end
        return logic'((cnt - vcnt / 2) & 1);
    endfunction

    // Predict at acceptance so the table matches the order the block sees.
    function automatic void predict_beat(t_pip_item it);
        t_pip_answer r;
        if (it.op == OP_VERTEX) begin
            poly_x[it.vertex_index] = it.vertex_x;
            poly_y[it.vertex_index] = it.vertex_y;
            r.inside_res = 1'b0;
            r.answered = 1'b0;
        end else begin
            r.inside_res = crossing_parity(it.query_x, it.query_y);
            r.answered = 1'b1;
        end
        answers_due.push_back(r);
    endfunction

    // Driver: present pending beats with random gaps, change at the falling edge.
    initial begin
        in_ch.valid = 1'b0;
        in_ch.op = 1'b0;
        in_ch.vertex_index = '0;
        in_ch.vertex_x = '0;
        in_ch.vertex_y = '0;
        in_ch.query_x = '0;
        in_ch.query_y = '0;
        out_ch.ready = 1'b0;
    end

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!in_ch.valid || in_taken) begin
                if (pending_items.size() > 0 && !hold_sender &&
                    !(idle_enable && $urandom_range(0, 99) < 14)) begin
                    in_ch.valid <= 1'b1;
                    in_ch.op <= pending_items[0].op;
                    in_ch.vertex_index <= pending_items[0].vertex_index;
                    in_ch.vertex_x <= pending_items[0].vertex_x;
                    in_ch.vertex_y <= pending_items[0].vertex_y;
                    in_ch.query_x <= pending_items[0].query_x;
                    in_ch.query_y <= pending_items[0].query_y;
                    void'(pending_items.pop_front());
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
            out_ch.ready <= !(idle_enable && $urandom_range(0, 99) < 14);
        end
    end

    // Monitor: take input beats into the predictor and check result beats.
    always @(posedge i_clk) begin
        t_pip_item it;
        t_pip_answer exp_r;
        cycle_count <= cycle_count + 1;
        in_taken <= i_rst_n && in_ch.valid && in_ch.ready;
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            it.op = in_ch.op;
            it.vertex_index = in_ch.vertex_index;
            it.vertex_x = in_ch.vertex_x;
            it.vertex_y = in_ch.vertex_y;
            it.query_x = in_ch.query_x;
            it.query_y = in_ch.query_y;
            predict_beat(it);
        end
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (answers_due.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) $display("unexpected result beat");
            end else begin
                exp_r = answers_due.pop_front();
                if (exp_r.inside_res !== out_ch.inside_res ||
                    exp_r.answered !== out_ch.answered) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected inside=%0d answered=%0d, got %0d %0d",
                                 exp_r.inside_res, exp_r.answered,
                                 out_ch.inside_res, out_ch.answered);
                end
            end
        end
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic t_pip_item vertex_item(int idx, int x, int y);
        t_pip_item it;
        it.op = OP_VERTEX;
        it.vertex_index = 6'(idx);
        it.vertex_x = 16'(x);
        it.vertex_y = 16'(y);
        it.query_x = $urandom();
        it.query_y = $urandom();
        return it;
    endfunction

    function automatic t_pip_item query_item(int qx, int qy);
        t_pip_item it;
        it.op = OP_QUERY;
        it.vertex_index = 6'($urandom());
        it.vertex_x = 16'($urandom());
        it.vertex_y = 16'($urandom());
        it.query_x = 32'(qx);
        it.query_y = 32'(qy);
        return it;
    endfunction

    // Wait until every queued beat is out and every answer is in, then let the block drain.
    task automatic drain_all();
        while (pending_items.size() > 0 || in_ch.valid || answers_due.size() > 0)
            @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic set_edges(int n);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= EC_W'(n);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        edge_setting = n;
    endtask

    // Random point near the polygon, often on vertex heights and grid points.
    function automatic t_pip_item random_query(int span);
        int qx, qy, k, pick;
        pick = $urandom_range(0, 9);
        k = $urandom_range(0, NVERT - 1);
        if (pick < 3) begin
            qx = $urandom_range(0, 2 * span) - span;
            qy = int'(poly_y[k % ((edge_setting < 3) ? 3 : edge_setting)]);
            qx = qx * 65536 + ($urandom_range(0, 1) ? 0 : $urandom_range(0, 65535));
            qy = qy * 65536;
        end else if (pick < 9) begin
            qx = ($urandom_range(0, 2 * span) - span) * 65536 + $urandom_range(0, 65535);
            qy = ($urandom_range(0, 2 * span) - span) * 65536 + $urandom_range(0, 65535);
        end else begin
            qx = $urandom();
            qy = $urandom();
        end
        return query_item(qx, qy);
    endfunction

    // Random polygon of n vertices, written into slots 0..n-1.
    task automatic load_polygon(int n, int span);
        int x, y;
        for (int i = 0; i < n; i++) begin
            if (span > 30000) begin
                x = $urandom_range(0, 65535) - 32768;
                y = $urandom_range(0, 65535) - 32768;
            end else begin
                x = $urandom_range(0, 2 * span) - span;
                y = $urandom_range(0, 2 * span) - span;
            end
            pending_items.push_back(vertex_item(i, x, y));
        end
    endtask

    initial begin
        int n, span, sizes[6];
        sizes = '{3, 4, 64, 5, 8, 3};
        for (int i = 0; i < NVERT; i++) begin
            poly_x[i] = 0;
            poly_y[i] = 0;
        end
        edge_setting = EC_RESET;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: triangle with a horizontal edge, extremes, boundary points.
        pending_items.push_back(vertex_item(0, 0, 0));
        pending_items.push_back(vertex_item(1, 10, 0));
        pending_items.push_back(vertex_item(2, 5, 10));
        pending_items.push_back(query_item(5 * 65536, 3 * 65536));
        pending_items.push_back(query_item(20 * 65536, 3 * 65536));
        pending_items.push_back(query_item(5 * 65536, 0));
        pending_items.push_back(query_item(0, 10 * 65536));
        pending_items.push_back(query_item(-2147483648, 0));
        pending_items.push_back(query_item(2147483647, -2147483648));
        pending_items.push_back(query_item(32'h0005_8000, 32'h0004_8000));
        drain_all();
        // Square with a zero-length edge and extreme coordinates.
        set_edges(5);
        pending_items.push_back(vertex_item(0, -32768, -32768));
        pending_items.push_back(vertex_item(1, 32767, -32768));
        pending_items.push_back(vertex_item(2, 32767, 32767));
        pending_items.push_back(vertex_item(3, 32767, 32767));
        pending_items.push_back(vertex_item(4, -32768, 32767));
        pending_items.push_back(query_item(0, 0));
        pending_items.push_back(query_item(32767 * 65536, 0));
        pending_items.push_back(query_item(-2147483648, 32767 * 65536));
        pending_items.push_back(query_item(0, -2147483648));
        pending_items.push_back(query_item(2147483647, 2147483647));
        drain_all();
        // Out-of-range edge counts clamp; low values act as three.
        set_edges(0);
        pending_items.push_back(query_item(0, 0));
        drain_all();
        set_edges(127);
        load_polygon(64, 40);
        pending_items.push_back(query_item(0, 0));
        drain_all();

        // Random phases, the second one with no idling.
        for (int ph = 0; ph < 12; ph++) begin
            idle_enable = (ph != 1);
            n = (ph % 6 == 2) ? 64 : ((ph == 9) ? 0 : sizes[ph % 6] + $urandom_range(0, 3));
            span = (ph == 7) ? 32767 : $urandom_range(2, 20);
            set_edges(n);
            if (n < 3) n = 3;
            load_polygon(n, span);
            drain_all();
            for (int q = 0; q < ((n > 16) ? 40 : 110); q++) begin
                if ($urandom_range(0, 19) == 0)
                    pending_items.push_back(vertex_item($urandom_range(0, n - 1),
                        $urandom_range(0, 2 * span) - span, $urandom_range(0, 2 * span) - span));
                else
                    pending_items.push_back(random_query(span));
                if (ph == 4 && q == 30) begin
                    // Hold the sender until every answer is in.
                    while (pending_items.size() > 0) @(posedge i_clk);
                    hold_sender = 1'b1;
                    while (in_ch.valid || answers_due.size() > 0) @(posedge i_clk);
                    hold_sender = 1'b0;
                end
            end
            drain_all();
        end

        if (mismatch_count == 0 && answers_due.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
